>>> design/tesd_pkg.sv
// Shared types, codes and constants of the touch edge swipe detector.
package tesd_pkg;

    localparam int POSITION_BITS = 16;
    localparam int DIST_BITS     = POSITION_BITS + 1;
    localparam int WIDE_BITS     = POSITION_BITS + 3;
    localparam int TDATA_BITS    = ((POSITION_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS  = 8;
    localparam int CFG_IDX_BITS  = 3;

    // Event kinds carried on s_tuser.
    localparam logic [1:0] KIND_TOUCH = 2'd0;
    localparam logic [1:0] KIND_X     = 2'd1;
    localparam logic [1:0] KIND_Y     = 2'd2;

    // Side codes; SIDE_NONE marks no edge being tracked.
    localparam logic [2:0] SIDE_LEFT   = 3'd0;
    localparam logic [2:0] SIDE_RIGHT  = 3'd1;
    localparam logic [2:0] SIDE_TOP    = 3'd2;
    localparam logic [2:0] SIDE_BOTTOM = 3'd3;
    localparam logic [2:0] SIDE_NONE   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_X_MIN     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_MAX     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MIN     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_MAX     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_MARGIN    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SENS      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd6;

    localparam logic [POSITION_BITS-1:0] RST_X_MIN     = POSITION_BITS'(0);
    localparam logic [POSITION_BITS-1:0] RST_X_MAX     = POSITION_BITS'(4095);
    localparam logic [POSITION_BITS-1:0] RST_Y_MIN     = POSITION_BITS'(0);
    localparam logic [POSITION_BITS-1:0] RST_Y_MAX     = POSITION_BITS'(4095);
    localparam logic [POSITION_BITS-1:0] RST_MARGIN    = POSITION_BITS'(16);
    localparam logic [POSITION_BITS-1:0] RST_SENS      = POSITION_BITS'(8);
    localparam logic [POSITION_BITS-1:0] RST_THRESHOLD = POSITION_BITS'(409);

    localparam logic signed [DIST_BITS-1:0] DIST_NONE = '1;  // -1

    typedef struct packed {
        logic [POSITION_BITS-1:0] x_min;
        logic [POSITION_BITS-1:0] x_max;
        logic [POSITION_BITS-1:0] y_min;
        logic [POSITION_BITS-1:0] y_max;
        logic [POSITION_BITS-1:0] edge_margin;
        logic [POSITION_BITS-1:0] move_sensitivity;
        logic [POSITION_BITS-1:0] swipe_threshold;
    } cfg_t;

    typedef struct packed {
        logic [2:0]                  held;
        logic signed [DIST_BITS-1:0] cur;
        logic signed [DIST_BITS-1:0] prev;
    } track_t;

endpackage

>>> design/touch_edge_swipe_detector.sv
// Top level of the touch edge swipe detector: event register, tracking state, result register.
//
//  channel  dir  handshake              payload
//  s_       in   s_tvalid / s_tready    s_tuser = kind, s_tdata = value
//  m_       out  m_tvalid / m_tready    m_tdata = edge_res
//  cfg_     in   cfg_valid / cfg_ready  cfg_addr = register index, cfg_wdata = value
//
// One event per cycle sustained while the result is not stalled; an event is
// judged in the event register, and a reported swipe is registered as it is judged.
// aresetn is synchronous, active low: it clears the tracking state to idle and
// loads the configuration defaults. A stalled result holds the event register,
// but one more event is still taken while that register is empty.
// The tracking state feeds back into itself each event, so it sets the rate.
module touch_edge_swipe_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [tesd_pkg::TDATA_BITS-1:0]     s_tdata,   // [15:0] value
    input  logic [1:0]                          s_tuser,   // [1:0] kind
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [tesd_pkg::M_TDATA_BITS-1:0]   m_tdata,   // [1:0] edge_res, rest zero
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tesd_pkg::CFG_IDX_BITS-1:0]   cfg_addr,
    input  logic [tesd_pkg::POSITION_BITS-1:0]  cfg_wdata
);

    tesd_pkg::cfg_t   cfg_reg;
    tesd_pkg::track_t state_reg;
    tesd_pkg::track_t state_next;

    logic                               in_valid_reg;
    logic [1:0]                         in_kind_reg;
    logic [tesd_pkg::POSITION_BITS-1:0] in_value_reg;
    logic                               out_valid_reg;
    logic [1:0]                         out_edge_reg;
    logic                               advance;
    logic                               emit;
    logic [1:0]                         edge_res;

    // Move the event register forward whenever the result slot is free or drains.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(tesd_pkg::M_TDATA_BITS-2){1'b0}}, out_edge_reg};

    // Configuration registers; writes beyond the list drop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_min            <= tesd_pkg::RST_X_MIN;
            cfg_reg.x_max            <= tesd_pkg::RST_X_MAX;
            cfg_reg.y_min            <= tesd_pkg::RST_Y_MIN;
            cfg_reg.y_max            <= tesd_pkg::RST_Y_MAX;
            cfg_reg.edge_margin      <= tesd_pkg::RST_MARGIN;
            cfg_reg.move_sensitivity <= tesd_pkg::RST_SENS;
            cfg_reg.swipe_threshold  <= tesd_pkg::RST_THRESHOLD;
        end else if (cfg_valid) begin
            case (cfg_addr)
                tesd_pkg::REG_X_MIN:     cfg_reg.x_min            <= cfg_wdata;
                tesd_pkg::REG_X_MAX:     cfg_reg.x_max            <= cfg_wdata;
                tesd_pkg::REG_Y_MIN:     cfg_reg.y_min            <= cfg_wdata;
                tesd_pkg::REG_Y_MAX:     cfg_reg.y_max            <= cfg_wdata;
                tesd_pkg::REG_MARGIN:    cfg_reg.edge_margin      <= cfg_wdata;
                tesd_pkg::REG_SENS:      cfg_reg.move_sensitivity <= cfg_wdata;
                tesd_pkg::REG_THRESHOLD: cfg_reg.swipe_threshold  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Event register: capture a word from the input channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg  <= s_tuser;
            in_value_reg <= s_tdata[tesd_pkg::POSITION_BITS-1:0];
        end
    end

    tesd_core u_core (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .kind       (in_kind_reg),
        .value      (in_value_reg),
        .state_next (state_next),
        .emit       (emit),
        .edge_res   (edge_res)
    );

    // Tracking state advances once per judged event.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.held <= tesd_pkg::SIDE_NONE;
            state_reg.cur  <= tesd_pkg::DIST_NONE;
            state_reg.prev <= tesd_pkg::DIST_NONE;
        end else if (advance && in_valid_reg) begin
            state_reg <= state_next;
        end
    end

    // Result register: hold a reported edge until the sink takes the word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && emit) begin
            out_edge_reg <= edge_res;
        end
    end

    // Idle means both distances sit at -1.
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.held == tesd_pkg::SIDE_NONE) |->
            (state_reg.cur == tesd_pkg::DIST_NONE && state_reg.prev == tesd_pkg::DIST_NONE))
        else $error("idle state with distances not cleared");

    // A report only follows a judged release event.
    a_rose_release: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |->
            $past(in_valid_reg && in_kind_reg == tesd_pkg::KIND_TOUCH && advance))
        else $error("result without a release event");

    // A stalled result freezes the tracking state.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(state_reg))
        else $error("tracking state moved while stalled");

    // A report always returns tracking to idle.
    a_report_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_valid_reg && emit) |=> (state_reg.held == tesd_pkg::SIDE_NONE))
        else $error("report without return to idle");

endmodule

>>> design/tesd_core.sv
// Per-event decision logic: next tracking state and swipe report for one event.
module tesd_core (
    input  tesd_pkg::cfg_t                    cfg,
    input  tesd_pkg::track_t                  state,
    input  logic [1:0]                        kind,
    input  logic [tesd_pkg::POSITION_BITS-1:0] value,
    output tesd_pkg::track_t                  state_next,
    output logic                              emit,
    output logic [1:0]                        edge_res
);

    localparam int W = tesd_pkg::WIDE_BITS;

    logic                  is_pos;
    logic [2:0]            low_edge;
    logic [2:0]            high_edge;
    logic signed [W-1:0]   lo_s;
    logic signed [W-1:0]   hi_s;
    logic signed [W-1:0]   v_s;
    logic signed [W-1:0]   margin_s;
    logic signed [W-1:0]   sens_s;
    logic signed [W-1:0]   thr_s;
    logic signed [W-1:0]   cur_s;
    logic signed [W-1:0]   prev_s;
    logic signed [W-1:0]   dist_s;
    logic signed [W-1:0]   diff_s;
    logic signed [W-1:0]   adiff_s;
    logic                  idle;
    logic                  on_axis;
    logic                  start_low;
    logic                  start_high;
    logic [2:0]            held_new;
    logic signed [W-1:0]   prev_start;
    logic                  release_ev;

    always_comb begin
        is_pos    = (kind == tesd_pkg::KIND_X) || (kind == tesd_pkg::KIND_Y);
        low_edge  = (kind == tesd_pkg::KIND_X) ? tesd_pkg::SIDE_LEFT : tesd_pkg::SIDE_TOP;
        high_edge = (kind == tesd_pkg::KIND_X) ? tesd_pkg::SIDE_RIGHT : tesd_pkg::SIDE_BOTTOM;
        lo_s      = (kind == tesd_pkg::KIND_X) ? W'(cfg.x_min) : W'(cfg.y_min);
        hi_s      = (kind == tesd_pkg::KIND_X) ? W'(cfg.x_max) : W'(cfg.y_max);
        v_s       = W'(value);
        margin_s  = W'(cfg.edge_margin);
        sens_s    = W'(cfg.move_sensitivity);
        thr_s     = W'(cfg.swipe_threshold);
        cur_s     = W'(state.cur);
        prev_s    = W'(state.prev);

        idle    = (state.held == tesd_pkg::SIDE_NONE);
        on_axis = (state.held == low_edge) || (state.held == high_edge);

        // Start a track only from idle; the low edge wins when both zones hit.
        start_low  = idle && (v_s < lo_s + margin_s);
        start_high = idle && !start_low && (v_s > hi_s - margin_s);
        held_new   = start_low ? low_edge : (start_high ? high_edge : state.held);
        prev_start = start_low ? lo_s : (start_high ? hi_s : prev_s);

        dist_s  = (held_new == low_edge) ? v_s : (hi_s - v_s);
        diff_s  = cur_s - dist_s;
        adiff_s = diff_s[W-1] ? -diff_s : diff_s;

        release_ev = (kind == tesd_pkg::KIND_TOUCH) && (value == '0) && !idle;

        state_next = state;
        emit       = 1'b0;
        edge_res   = state.held[1:0];

        if (release_ev) begin
            emit       = (cur_s > thr_s) && (cur_s >= prev_s);
            state_next.held = tesd_pkg::SIDE_NONE;
            state_next.cur  = tesd_pkg::DIST_NONE;
            state_next.prev = tesd_pkg::DIST_NONE;
        end else if (is_pos && (idle || on_axis) && (held_new != tesd_pkg::SIDE_NONE)) begin
            state_next.held = held_new;
            state_next.prev = tesd_pkg::DIST_BITS'(prev_start);
            if (adiff_s > sens_s) begin
                state_next.prev = state.cur;
                state_next.cur  = tesd_pkg::DIST_BITS'(dist_s);
            end
        end
    end

endmodule

>>> tb/touch_edge_swipe_detector_tb.sv
// Self-checking testbench for the touch edge swipe detector: directed events, then random gestures.
`timescale 1ns / 100ps

module touch_edge_swipe_detector_tb;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_LIMIT    = 5000;   // cycles without any accepted word
    localparam int SETTLE_CYCLES = 8;      // event register plus result register, with margin
    localparam int PHASES        = 8;
    localparam int PHASE_EVENTS  = 210;
    localparam int POS_TOP       = (1 << tesd_pkg::POSITION_BITS) - 1;

    // Kind three is not defined by the block and must be dropped.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    // Index one past the register list; a write here must change nothing.
    localparam logic [tesd_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

    // Predicts swipe reports from the accepted events and keeps the reports still owed.
    class swipe_tracker;
        tesd_pkg::cfg_t                        regs;
        logic [2:0]                            held;
        logic signed [tesd_pkg::DIST_BITS-1:0] cur_dist;
        logic signed [tesd_pkg::DIST_BITS-1:0] prev_dist;
        logic [1:0]                            pending_edges[$];
        int                                    mismatches;

        function new();
            regs.x_min            = tesd_pkg::RST_X_MIN;
            regs.x_max            = tesd_pkg::RST_X_MAX;
            regs.y_min            = tesd_pkg::RST_Y_MIN;
            regs.y_max            = tesd_pkg::RST_Y_MAX;
            regs.edge_margin      = tesd_pkg::RST_MARGIN;
            regs.move_sensitivity = tesd_pkg::RST_SENS;
            regs.swipe_threshold  = tesd_pkg::RST_THRESHOLD;
            held       = tesd_pkg::SIDE_NONE;
            cur_dist   = tesd_pkg::DIST_NONE;
            prev_dist  = tesd_pkg::DIST_NONE;
            mismatches = 0;
        endfunction

        function void set_reg(logic [tesd_pkg::CFG_IDX_BITS-1:0] idx,
                              logic [tesd_pkg::POSITION_BITS-1:0] data);
            case (idx)
                tesd_pkg::REG_X_MIN:     regs.x_min = data;
                tesd_pkg::REG_X_MAX:     regs.x_max = data;
                tesd_pkg::REG_Y_MIN:     regs.y_min = data;
                tesd_pkg::REG_Y_MAX:     regs.y_max = data;
                tesd_pkg::REG_MARGIN:    regs.edge_margin = data;
                tesd_pkg::REG_SENS:      regs.move_sensitivity = data;
                tesd_pkg::REG_THRESHOLD: regs.swipe_threshold = data;
                default: ;
            endcase
        endfunction

        // One position on an axis whose low edge code is low_edge.
        function void follow_axis(logic [2:0] low_edge, longint lo, longint hi, longint v);
            logic [2:0] high_edge;
            longint     margin, sens, cur, reach, diff;
            high_edge = low_edge + 3'd1;
            margin    = longint'(regs.edge_margin);
            sens      = longint'(regs.move_sensitivity);
            if (held != tesd_pkg::SIDE_NONE && held != low_edge && held != high_edge)
                return;
            if (held == tesd_pkg::SIDE_NONE) begin
                // low zone is tested first, so it wins where the zones overlap
                if (v < lo + margin) begin
                    held      = low_edge;
                    prev_dist = tesd_pkg::DIST_BITS'(lo);
                end else if (v > hi - margin) begin
                    held      = high_edge;
                    prev_dist = tesd_pkg::DIST_BITS'(hi);
                end
            end
            if (held == tesd_pkg::SIDE_NONE)
                return;
            reach = (held == low_edge) ? v : hi - v;
            cur   = longint'(cur_dist);
            diff  = cur - reach;
            if (diff < 0)
                diff = -diff;
            if (diff > sens) begin
                prev_dist = cur_dist;
                cur_dist  = tesd_pkg::DIST_BITS'(reach);
            end
        endfunction

        function void take_event(logic [1:0] kind, logic [tesd_pkg::POSITION_BITS-1:0] value);
            longint cur, prev, thr;
            cur  = longint'(cur_dist);
            prev = longint'(prev_dist);
            thr  = longint'(regs.swipe_threshold);
            case (kind)
                tesd_pkg::KIND_TOUCH: begin
                    if (value == '0 && held != tesd_pkg::SIDE_NONE) begin
                        if (cur > thr && cur >= prev)
                            pending_edges.push_back(held[1:0]);
                        held      = tesd_pkg::SIDE_NONE;
                        cur_dist  = tesd_pkg::DIST_NONE;
                        prev_dist = tesd_pkg::DIST_NONE;
                    end
                end
                tesd_pkg::KIND_X:  follow_axis(tesd_pkg::SIDE_LEFT, longint'(regs.x_min),
                                               longint'(regs.x_max), longint'(value));
                tesd_pkg::KIND_Y:  follow_axis(tesd_pkg::SIDE_TOP, longint'(regs.y_min),
                                               longint'(regs.y_max), longint'(value));
                default: ;
            endcase
        endfunction

        function void check_swipe(logic [tesd_pkg::M_TDATA_BITS-1:0] got);
            logic [tesd_pkg::M_TDATA_BITS-1:0] want;
            if (pending_edges.size() == 0) begin
                $display("%0t: swipe reported with none owed, expected none, actual %0d",
                         $time, got);
                mismatches++;
                return;
            end
            want = tesd_pkg::M_TDATA_BITS'(pending_edges.pop_front());
            if (got !== want) begin
                $display("%0t: swipe edge mismatch, expected %0d, actual %0d", $time, want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [tesd_pkg::TDATA_BITS-1:0]     s_tdata   = '0;   // [15:0] value
    logic [1:0]                          s_tuser   = '0;   // [1:0] kind
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    logic [tesd_pkg::M_TDATA_BITS-1:0]   m_tdata;          // [1:0] edge_res, rest zero
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [tesd_pkg::CFG_IDX_BITS-1:0]   cfg_addr  = '0;
    logic [tesd_pkg::POSITION_BITS-1:0]  cfg_wdata = '0;

    swipe_tracker tracker = new();

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int idle_cycles    = 0;
    int events_taken   = 0;
    int swipes_seen    = 0;
    int cfg_writes     = 0;

    touch_edge_swipe_detector dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Drop m_tready at random; the rate is set per phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Sample every channel at the edge, before any nonblocking update lands,
    // so each handshake is seen with the values the block saw.
    always @(posedge aclk) begin
        bit moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tracker.take_event(s_tuser, s_tdata[tesd_pkg::POSITION_BITS-1:0]);
                events_taken++;
                moved = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                tracker.check_swipe(m_tdata);
                swipes_seen++;
                moved = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                tracker.set_reg(cfg_addr, cfg_wdata);
                cfg_writes++;
                moved = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: end the run once nothing has moved for too long.
    initial begin
        do @(posedge aclk); while (idle_cycles < IDLE_LIMIT);
        $display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    function automatic int clamp_pos(int p);
        if (p < 0)
            return 0;
        if (p > POS_TOP)
            return POS_TOP;
        return p;
    endfunction

    // Offer one event word, idling first at the phase's rate; return once taken.
    task automatic send_event(input logic [1:0] kind,
                              input logic [tesd_pkg::POSITION_BITS-1:0] value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= tesd_pkg::TDATA_BITS'(value);
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the source off until every owed swipe is out, then let the pipe settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (tracker.pending_edges.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tesd_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [tesd_pkg::POSITION_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        tesd_pkg::cfg_t                     c;
        int                                 phase, sent, steps, pos, stride, span, lo, hi, margin;
        bit                                 from_high, paused;
        logic [1:0]                         axis, nk;
        logic [tesd_pkg::POSITION_BITS-1:0] nv;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed events on the reset setup.
        send_event(KIND_SPARE, 16'hFFFF);                 // undefined kind: drop
        send_event(tesd_pkg::KIND_TOUCH, 16'd0);          // release while idle
        send_event(tesd_pkg::KIND_TOUCH, 16'd1);          // press: ignored
        send_event(tesd_pkg::KIND_TOUCH, 16'h8000);       // odd touch value: ignored
        send_event(tesd_pkg::KIND_X, 16'd5);              // start on the left edge
        send_event(tesd_pkg::KIND_Y, 16'd4000);           // other axis while held
        send_event(tesd_pkg::KIND_X, 16'd600);
        send_event(tesd_pkg::KIND_X, 16'd604);            // change below sensitivity
        send_event(tesd_pkg::KIND_TOUCH, 16'd1);
        send_event(tesd_pkg::KIND_TOUCH, 16'd0);          // left swipe
        send_event(tesd_pkg::KIND_X, 16'd4090);           // start on the right edge
        send_event(tesd_pkg::KIND_X, 16'd3000);
        send_event(tesd_pkg::KIND_X, 16'd3500);           // backs off toward the edge
        send_event(tesd_pkg::KIND_TOUCH, 16'd0);          // shrinking distance: no report
        send_event(tesd_pkg::KIND_Y, 16'd0);              // top edge
        send_event(tesd_pkg::KIND_Y, 16'hFFFF);
        send_event(tesd_pkg::KIND_TOUCH, 16'd0);          // top swipe
        send_event(tesd_pkg::KIND_Y, 16'd4095);           // bottom edge
        send_event(tesd_pkg::KIND_Y, 16'd1000);
        send_event(tesd_pkg::KIND_X, 16'd0);
        send_event(tesd_pkg::KIND_TOUCH, 16'd0);          // bottom swipe
        send_event(tesd_pkg::KIND_X, 16'hFFFF);           // past the right bound
        send_event(tesd_pkg::KIND_TOUCH, 16'd0);
        send_event(tesd_pkg::KIND_TOUCH, 16'd0);

        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase

            // Pick this phase's screen geometry and tuning.
            case (phase)
                0: c = {tesd_pkg::RST_X_MIN, tesd_pkg::RST_X_MAX,
                        tesd_pkg::RST_Y_MIN, tesd_pkg::RST_Y_MAX,
                        tesd_pkg::RST_MARGIN, tesd_pkg::RST_SENS, tesd_pkg::RST_THRESHOLD};
                1: c = {16'd100, 16'd1100, 16'd50, 16'd800, 16'd30, 16'd4, 16'd200};
                2: c = {16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
                3: c = {16'hFFFF, 16'd0, 16'd20000, 16'd10000, 16'd0, 16'hFFFF, 16'hFFFF};
                4: c = {16'd0, 16'd4095, 16'd1000, 16'd2000, 16'd3000, 16'd8, 16'd100};
                5: c = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom)};
                6: begin
                    lo = $urandom_range(5000);
                    hi = clamp_pos(lo + int'($urandom_range(60000, 500)));
                    c.x_min = 16'(lo);
                    c.x_max = 16'(hi);
                    lo = $urandom_range(5000);
                    hi = clamp_pos(lo + int'($urandom_range(60000, 500)));
                    c.y_min = 16'(lo);
                    c.y_max = 16'(hi);
                    c.edge_margin      = 16'($urandom_range(500));
                    c.move_sensitivity = 16'($urandom_range(50));
                    c.swipe_threshold  = 16'($urandom_range(hi - lo));
                end
                default: c = {16'd0, 16'd4095, 16'd0, 16'd4095, 16'd1, 16'd0, 16'd0};
            endcase
            write_reg(tesd_pkg::REG_X_MIN, c.x_min);
            write_reg(tesd_pkg::REG_X_MAX, c.x_max);
            write_reg(tesd_pkg::REG_Y_MIN, c.y_min);
            write_reg(tesd_pkg::REG_Y_MAX, c.y_max);
            write_reg(tesd_pkg::REG_MARGIN, c.edge_margin);
            write_reg(tesd_pkg::REG_SENS, c.move_sensitivity);
            write_reg(tesd_pkg::REG_THRESHOLD, c.swipe_threshold);
            if (phase == 0)
                write_reg(REG_UNUSED, 16'h5A5A);

            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_EVENTS) begin
                // Halfway through, hold the source until all owed swipes are out.
                if (!paused && sent >= PHASE_EVENTS / 2) begin
                    paused = 1'b1;
                    drain();
                end
                if ($urandom_range(3) != 0) begin
                    // A gesture: touch down near an edge, drag away, lift.
                    axis      = $urandom_range(1) ? tesd_pkg::KIND_Y : tesd_pkg::KIND_X;
                    lo        = (axis == tesd_pkg::KIND_X) ? int'(tracker.regs.x_min)
                                                           : int'(tracker.regs.y_min);
                    hi        = (axis == tesd_pkg::KIND_X) ? int'(tracker.regs.x_max)
                                                           : int'(tracker.regs.y_max);
                    margin    = int'(tracker.regs.edge_margin);
                    from_high = 1'($urandom_range(1));
                    // land inside the zone, or just outside it now and then
                    if (from_high)
                        pos = clamp_pos(hi - int'($urandom_range(margin + 1)) + 1);
                    else
                        pos = clamp_pos(lo + int'($urandom_range(margin + 1)) - 1);
                    span  = (hi > lo) ? hi - lo : lo - hi;
                    steps = $urandom_range(12, 1);
                    send_event(axis, tesd_pkg::POSITION_BITS'(pos));
                    repeat (steps) begin
                        case ($urandom_range(9))
                            0: send_event((axis == tesd_pkg::KIND_X) ? tesd_pkg::KIND_Y
                                                                     : tesd_pkg::KIND_X,
                                          tesd_pkg::POSITION_BITS'($urandom));
                            1: send_event(tesd_pkg::KIND_TOUCH,
                                          tesd_pkg::POSITION_BITS'($urandom_range(3, 1)));
                            2: send_event(KIND_SPARE, tesd_pkg::POSITION_BITS'($urandom));
                            default: begin
                                stride = $urandom_range(span / 3 +
                                         2 * int'(tracker.regs.move_sensitivity) + 2);
                                // now and then slip back toward the edge
                                if ($urandom_range(4) == 0)
                                    stride = -stride / 2;
                                pos = clamp_pos(from_high ? pos - stride : pos + stride);
                                send_event(axis, tesd_pkg::POSITION_BITS'(pos));
                            end
                        endcase
                    end
                    send_event(tesd_pkg::KIND_TOUCH, '0);
                    sent += steps + 2;
                end else begin
                    // Noise: any kind, any value, touch values leaning to press and release.
                    nk = 2'($urandom_range(3));
                    nv = tesd_pkg::POSITION_BITS'($urandom);
                    if (nk == tesd_pkg::KIND_TOUCH && $urandom_range(2) != 0)
                        nv = tesd_pkg::POSITION_BITS'($urandom_range(1));
                    send_event(nk, nv);
                    sent++;
                end
            end
        end

        drain();
        $display("summary: %0d touch events over %0d setups and %0d register writes,",
                 events_taken, PHASES + 1, cfg_writes);
        $display("summary: %0d swipes reported, %0d mismatches", swipes_seen,
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> touch_edge_swipe_detector.f
design/tesd_pkg.sv
design/tesd_core.sv
design/touch_edge_swipe_detector.sv
tb/touch_edge_swipe_detector_tb.sv
